>>> src/pft_pkg.sv
// Package for the physical frame table: transaction types, codes and constants.
// No dependencies.
`default_nettype none
package pft_pkg;
	localparam int FRAME_COUNT_DEF = 1024;
	localparam int ADDR_LIMIT = 1024;
	localparam logic [10:0] NO_PARENT = 11'h7FF;
	localparam logic [10:0] COUNT_MAX = 11'h7FF;

	localparam logic [2:0] KIND_ALLOC   = 3'd0;
	localparam logic [2:0] KIND_LOOKUP  = 3'd1;
	localparam logic [2:0] KIND_FREE    = 3'd2;
	localparam logic [2:0] KIND_RETAIN  = 3'd3;
	localparam logic [2:0] KIND_RELEASE = 3'd4;

	localparam logic [1:0] FT_PAGE  = 2'd0;
	localparam logic [1:0] FT_TABLE = 2'd1;
	localparam logic [1:0] FT_DIR   = 2'd2;

	typedef struct packed {
		logic [2:0]  kind;
		logic [5:0]  owner;
		logic [19:0] page_number;
		logic [1:0]  frame_kind;
		logic [9:0]  parent_frame;
		logic        parent_present;
		logic [9:0]  target_frame;
	} cmd_t;

	typedef struct packed {
		logic [9:0]  frame_index;
		logic        success;
		logic        needs_writeback;
		logic [5:0]  freed_owner;
		logic [19:0] freed_page;
		logic [1:0]  freed_kind;
		logic        freed;
		logic        last;
	} res_t;

	// One frame entry as stored in RAM: mapped flag, owner, page, type, parent, count.
	typedef struct packed {
		logic        mapped;
		logic [5:0]  owner;
		logic [19:0] page;
		logic [1:0]  ftype;
		logic [10:0] parent;
		logic [10:0] count;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);
endpackage
`default_nettype wire

>>> src/pft_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module pft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read on one port.
	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

>>> src/physical_frame_table.sv
// Physical frame table top level: sequencer around one entry RAM.
// Depends on pft_pkg and pft_ram.
//
//  channel | handshake        | payload
//  command | start / busy     | cmd (pft_pkg::cmd_t)
//  result  | res_valid strobe | res (pft_pkg::res_t)
//
// Allocate and lookup scan the entry RAM frame by frame (S_SREAD, S_SCHK) until
// a match or the last used frame. Retain and release read and check the target
// (S_TREAD, S_TCHK); a free, or a release to zero, clears the frame (S_FREE) and
// may climb to its parent (S_PREAD, S_PCHK), at most three frames. Unknown kinds
// and out-of-range targets answer from S_REPLY. The scan is bound by the single
// RAM port. After reset a clearing pass writes every entry while busy is high.
// Each result stands for one cycle; the receiver cannot stall.
`default_nettype none
module physical_frame_table #(
	parameter int FRAME_COUNT = pft_pkg::FRAME_COUNT_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire pft_pkg::cmd_t cmd,
	output logic               busy,
	output logic               res_valid,
	output pft_pkg::res_t      res
);
	import pft_pkg::*;

	localparam int AW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
	localparam int USED = (FRAME_COUNT < ADDR_LIMIT) ? FRAME_COUNT : ADDR_LIMIT;

	typedef enum logic [9:0] {
		S_CLEAR = 10'b0000000001,
		S_IDLE  = 10'b0000000010,
		S_SREAD = 10'b0000000100,
		S_SCHK  = 10'b0000001000,
		S_TREAD = 10'b0000010000,
		S_TCHK  = 10'b0000100000,
		S_FREE  = 10'b0001000000,
		S_PREAD = 10'b0010000000,
		S_PCHK  = 10'b0100000000,
		S_REPLY = 10'b1000000000
	} state_t;

	state_t state_q;
	cmd_t cmd_q;
	entry_t cur_q;
	logic [AW-1:0] idx_q;
	logic [1:0] nfreed_q;
	logic [AW-1:0] clr_q;

	logic ram_we;
	logic [AW-1:0] ram_addr;
	entry_t ram_wd, ram_rd;

	pft_ram #(.WIDTH(ENTRY_W), .DEPTH(FRAME_COUNT)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd)
	);

	assign busy = (state_q != S_IDLE);

	logic [10:0] dec_cnt;
	assign dec_cnt = (ram_rd.count != 11'd0) ? ram_rd.count - 11'd1 : 11'd0;

	// The frame being freed may climb to its parent: a page or table, not the
	// third freed frame, and a parent inside the used range.
	logic climb;
	assign climb = (cur_q.ftype < FT_DIR) && (nfreed_q != 2'd2) &&
		(cur_q.parent != NO_PARENT) && (cur_q.parent < 11'(USED));

	// The parent just read is mapped and its count drops to (or stays at) zero.
	logic next_free;
	assign next_free = ram_rd.mapped && (dec_cnt == 11'd0);

	logic scan_end;
	assign scan_end = (idx_q == AW'(USED - 1));

	logic tgt_in;
	assign tgt_in = ({1'b0, cmd.target_frame} < 11'(USED));

	// Result that reports the frame being freed.
	res_t freed_res;
	always_comb begin
		freed_res = '0;
		freed_res.frame_index = 10'(idx_q);
		freed_res.success = 1'b1;
		freed_res.needs_writeback = (cur_q.ftype == FT_PAGE);
		freed_res.freed_owner = cur_q.owner;
		freed_res.freed_page = cur_q.page;
		freed_res.freed_kind = cur_q.ftype;
		freed_res.freed = 1'b1;
	end

	// RAM port and result generation.
	always_comb begin
		ram_we = 1'b0;
		ram_addr = idx_q;
		ram_wd = ram_rd;
		res_valid = 1'b0;
		res = '0;
		unique case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				ram_addr = clr_q;
				ram_wd = '0;
				ram_wd.parent = NO_PARENT;
			end
			S_SCHK: begin
				if (cmd_q.kind == KIND_ALLOC && !ram_rd.mapped) begin
					ram_we = 1'b1;
					ram_wd.mapped = 1'b1;
					ram_wd.owner = cmd_q.owner;
					ram_wd.page = cmd_q.page_number;
					ram_wd.ftype = cmd_q.frame_kind;
					ram_wd.parent = cmd_q.parent_present ? {1'b0, cmd_q.parent_frame} : NO_PARENT;
					ram_wd.count = 11'd1;
					res_valid = 1'b1;
					res.frame_index = 10'(idx_q);
					res.success = 1'b1;
					res.last = 1'b1;
				end else if (cmd_q.kind == KIND_LOOKUP && ram_rd.mapped &&
						ram_rd.ftype == FT_PAGE && ram_rd.owner == cmd_q.owner &&
						ram_rd.page == cmd_q.page_number) begin
					res_valid = 1'b1;
					res.frame_index = 10'(idx_q);
					res.success = 1'b1;
					res.last = 1'b1;
				end else if (scan_end) begin
					res_valid = 1'b1;
					res.last = 1'b1;
				end
			end
			S_TCHK: begin
				if (!ram_rd.mapped) begin
					res_valid = 1'b1;
					res.frame_index = cmd_q.target_frame;
					res.last = 1'b1;
				end else if (cmd_q.kind == KIND_RETAIN) begin
					ram_we = 1'b1;
					if (ram_rd.count != COUNT_MAX) ram_wd.count = ram_rd.count + 11'd1;
					res_valid = 1'b1;
					res.frame_index = cmd_q.target_frame;
					res.success = 1'b1;
					res.last = 1'b1;
				end else if (cmd_q.kind == KIND_RELEASE && dec_cnt != 11'd0) begin
					ram_we = 1'b1;
					ram_wd.count = dec_cnt;
					res_valid = 1'b1;
					res.frame_index = cmd_q.target_frame;
					res.success = 1'b1;
					res.last = 1'b1;
				end
			end
			S_FREE: begin
				ram_we = 1'b1;
				ram_wd = cur_q;
				ram_wd.mapped = 1'b0;
				ram_wd.count = 11'd0;
				if (!climb) begin
					res_valid = 1'b1;
					res = freed_res;
					res.last = 1'b1;
				end
			end
			S_PREAD: ram_addr = AW'(cur_q.parent);
			S_PCHK: begin
				ram_addr = AW'(cur_q.parent);
				ram_we = ram_rd.mapped;
				ram_wd.count = dec_cnt;
				res_valid = 1'b1;
				res = freed_res;
				res.last = !next_free;
			end
			S_REPLY: begin
				res_valid = 1'b1;
				res.last = 1'b1;
				if (cmd_q.kind <= KIND_RELEASE) res.frame_index = cmd_q.target_frame;
			end
			default: ;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cur_q <= '0;
			idx_q <= '0;
			nfreed_q <= '0;
			clr_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(FRAME_COUNT - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					nfreed_q <= '0;
					if (start) begin
						if (cmd.kind == KIND_ALLOC || cmd.kind == KIND_LOOKUP) begin
							idx_q <= '0;
							state_q <= S_SREAD;
						end else if (cmd.kind > KIND_RELEASE || !tgt_in) begin
							state_q <= S_REPLY;
						end else begin
							idx_q <= AW'(cmd.target_frame);
							state_q <= S_TREAD;
						end
					end
				end
				S_SREAD: state_q <= S_SCHK;
				S_SCHK: begin
					if (res_valid) state_q <= S_IDLE;
					else begin
						idx_q <= idx_q + AW'(1);
						state_q <= S_SREAD;
					end
				end
				S_TREAD: state_q <= S_TCHK;
				S_TCHK: begin
					cur_q <= ram_rd;
					if (res_valid) state_q <= S_IDLE;
					else state_q <= S_FREE;
				end
				S_FREE: state_q <= climb ? S_PREAD : S_IDLE;
				S_PREAD: state_q <= S_PCHK;
				S_PCHK: begin
					if (next_free) begin
						idx_q <= AW'(cur_q.parent);
						cur_q <= ram_rd;
						nfreed_q <= nfreed_q + 2'd1;
						state_q <= S_FREE;
					end else state_q <= S_IDLE;
				end
				S_REPLY: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Command register, loaded when a transaction is taken.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) cmd_q <= cmd;
	end

	assert property (@(posedge clk) disable iff (!arst_n) res_valid |-> busy);
	assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q));
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FREE) |-> (nfreed_q != 2'd3));
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |=> (state_q == S_IDLE || state_q == S_SREAD ||
			state_q == S_TREAD || state_q == S_REPLY));
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.last) |=> busy);
endmodule
`default_nettype wire

>>> sim/pft_checker.sv
// Checker for the physical frame table: watches command and result transactions,
// predicts the results from its own frame table copy and compares them.
// Depends on pft_pkg.
`timescale 1ns / 100ps
module pft_checker (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          busy,
	input  wire pft_pkg::cmd_t cmd,
	input  wire logic          res_valid,
	input  wire pft_pkg::res_t res,
	output int                 fail_count,
	output int                 pending
);
	import pft_pkg::*;

	localparam int FRAMES = 1024;

	logic        mapped [FRAMES];
	logic [5:0]  owner_of [FRAMES];
	logic [19:0] page_of [FRAMES];
	logic [1:0]  type_of [FRAMES];
	logic [10:0] parent_of [FRAMES];
	logic [10:0] refs [FRAMES];

	res_t expected_results [$];
	int   result_total;

	assign pending = expected_results.size();

	// Clear the copy of the table.
	task automatic clear_table();
		for (int i = 0; i < FRAMES; i++) begin
			mapped[i] = 1'b0;
			owner_of[i] = '0;
			page_of[i] = '0;
			type_of[i] = '0;
			parent_of[i] = NO_PARENT;
			refs[i] = '0;
		end
	endtask

	// Free a mapped frame and walk up through parents whose count drops to zero.
	task automatic free_cascade(input int first, ref res_t outs [$]);
		int cur;
		int n;
		logic [10:0] par;
		res_t r;
		cur = first;
		n = 0;
		while (n < 3) begin
			par = parent_of[cur];
			r = '0;
			r.frame_index = cur[9:0];
			r.success = 1'b1;
			r.needs_writeback = (type_of[cur] == FT_PAGE);
			r.freed_owner = owner_of[cur];
			r.freed_page = page_of[cur];
			r.freed_kind = type_of[cur];
			r.freed = 1'b1;
			outs.push_back(r);
			n++;
			mapped[cur] = 1'b0;
			refs[cur] = '0;
			if (type_of[cur] >= FT_DIR || n >= 3) break;
			if (par == NO_PARENT || par >= FRAMES || !mapped[par]) break;
			if (refs[par] > 0) refs[par] = refs[par] - 11'd1;
			if (refs[par] != 0) break;
			cur = int'(par);
		end
	endtask

	// Work out the results of one command transaction.
	task automatic predict_command(input cmd_t c);
		res_t outs [$];
		res_t r;
		logic ok;
		int t;
		r = '0;
		t = int'(c.target_frame);
		ok = mapped[t];
		case (c.kind)
			KIND_ALLOC: begin
				for (int i = 0; i < FRAMES; i++) begin
					if (!mapped[i]) begin
						mapped[i] = 1'b1;
						owner_of[i] = c.owner;
						page_of[i] = c.page_number;
						type_of[i] = c.frame_kind;
						parent_of[i] = c.parent_present ? {1'b0, c.parent_frame} : NO_PARENT;
						refs[i] = 11'd1;
						r.frame_index = i[9:0];
						r.success = 1'b1;
						break;
					end
				end
				outs.push_back(r);
			end
			KIND_LOOKUP: begin
				for (int i = 0; i < FRAMES; i++) begin
					if (mapped[i] && type_of[i] == FT_PAGE && owner_of[i] == c.owner
						&& page_of[i] == c.page_number) begin
						r.frame_index = i[9:0];
						r.success = 1'b1;
						break;
					end
				end
				outs.push_back(r);
			end
			KIND_FREE: begin
				if (ok) free_cascade(t, outs);
				else begin
					r.frame_index = c.target_frame;
					outs.push_back(r);
				end
			end
			KIND_RETAIN: begin
				if (ok && refs[t] < COUNT_MAX) refs[t] = refs[t] + 11'd1;
				r.frame_index = c.target_frame;
				r.success = ok;
				outs.push_back(r);
			end
			KIND_RELEASE: begin
				if (ok && refs[t] > 0) refs[t] = refs[t] - 11'd1;
				if (ok && refs[t] == 0) free_cascade(t, outs);
				else begin
					r.frame_index = c.target_frame;
					r.success = ok;
					outs.push_back(r);
				end
			end
			default: outs.push_back(r);
		endcase
		outs[outs.size() - 1].last = 1'b1;
		foreach (outs[k]) expected_results.push_back(outs[k]);
	endtask

	task automatic report(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
		$error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
		fail_count++;
	endtask

	// Compare one result transaction with the oldest expectation.
	task automatic check_result(input res_t a);
		res_t e;
		if (expected_results.size() == 0) begin
			$error("unexpected result transaction: frame %0d", a.frame_index);
			fail_count++;
			return;
		end
		e = expected_results.pop_front();
		if (a.frame_index !== e.frame_index)
			report("frame_index", 32'(e.frame_index), 32'(a.frame_index));
		if (a.success !== e.success) report("success", 32'(e.success), 32'(a.success));
		if (a.needs_writeback !== e.needs_writeback)
			report("needs_writeback", 32'(e.needs_writeback), 32'(a.needs_writeback));
		if (a.freed_owner !== e.freed_owner)
			report("freed_owner", 32'(e.freed_owner), 32'(a.freed_owner));
		if (a.freed_page !== e.freed_page)
			report("freed_page", 32'(e.freed_page), 32'(a.freed_page));
		if (a.freed_kind !== e.freed_kind)
			report("freed_kind", 32'(e.freed_kind), 32'(a.freed_kind));
		if (a.freed !== e.freed) report("freed", 32'(e.freed), 32'(a.freed));
		if (a.last !== e.last) report("last", 32'(e.last), 32'(a.last));
	endtask

	initial begin
		fail_count = 0;
		result_total = 0;
		clear_table();
	end

	// Results are checked before new commands so one edge never mixes the two.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid) begin
				check_result(res);
				result_total++;
			end
			if (start && !busy) predict_command(cmd);
		end
	end
endmodule

>>> sim/tb_top.sv
// Testbench top for the physical frame table: drives command transactions
// with random gaps and gives the verdict. Depends on pft_pkg and pft_checker.
`timescale 1ns / 100ps
module tb_top;
	import pft_pkg::*;

	localparam longint CYCLE_LIMIT = 4000000;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  start = 1'b0;
	cmd_t  cmd = '0;
	logic  busy;
	logic  res_valid;
	res_t  res;
	int    fail_count;
	int    pending;
	longint cycles = 0;
	int    sent = 0;

	physical_frame_table dut (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd),
		.busy(busy), .res_valid(res_valid), .res(res)
	);

	pft_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.res_valid(res_valid), .res(res), .fail_count(fail_count), .pending(pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Hand one command over and wait until it is taken; start drops before the
	// next command can raise it again.
	task automatic send(input cmd_t c, input bit gaps);
		while (gaps && $urandom_range(99) < 22) @(posedge clk);
		cmd <= c;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		start <= 1'b0;
		sent++;
		@(posedge clk);
	endtask

	function automatic cmd_t make_cmd(input logic [2:0] k, input int tgt);
		cmd_t c;
		c = cmd_t'($bits(cmd_t)'({$urandom, $urandom}));
		c.kind = k;
		c.frame_kind = 2'($urandom_range(2));
		c.target_frame = 10'(tgt);
		return c;
	endfunction

	// Allocate a directory, a table under it and a page under that.
	task automatic build_chain(input bit gaps, input int base);
		cmd_t c;
		c = make_cmd(KIND_ALLOC, 0);
		c.frame_kind = FT_DIR;
		c.parent_present = 1'b0;
		send(c, gaps);
		c = make_cmd(KIND_ALLOC, 0);
		c.frame_kind = FT_TABLE;
		c.parent_present = 1'b1;
		c.parent_frame = 10'(base);
		send(c, gaps);
		c = make_cmd(KIND_ALLOC, 0);
		c.frame_kind = FT_PAGE;
		c.parent_present = 1'b1;
		c.parent_frame = 10'(base + 1);
		send(c, gaps);
	endtask

	initial begin
		cmd_t c;
		bit gaps;
		int guard;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: operations on an empty table, extremes of the fields.
		send(make_cmd(KIND_LOOKUP, 0), 0);
		send(make_cmd(KIND_FREE, 1023), 0);
		send(make_cmd(KIND_RETAIN, 0), 0);
		send(make_cmd(KIND_RELEASE, 5), 0);
		c = '1; c.kind = 3'd7; send(c, 0);
		c = '0; c.kind = 3'd5; send(c, 0);
		// A full chain at frames 0..2, then release the page: three frames go.
		build_chain(0, 0);
		c = make_cmd(KIND_LOOKUP, 0);
		c.owner = '1; c.page_number = '1;
		send(c, 0);
		send(make_cmd(KIND_RETAIN, 1), 0);
		send(make_cmd(KIND_RELEASE, 1), 0);
		send(make_cmd(KIND_RELEASE, 2), 0);
		send(make_cmd(KIND_FREE, 1), 0);
		send(make_cmd(KIND_FREE, 0), 0);
		// Page with a parent that is not mapped, freed directly.
		c = make_cmd(KIND_ALLOC, 0);
		c.frame_kind = FT_PAGE; c.parent_present = 1'b1; c.parent_frame = 10'd1023;
		send(c, 0);
		send(make_cmd(KIND_FREE, 0), 0);
		// A frame of type 3 does not cascade.
		c = make_cmd(KIND_ALLOC, 0);
		c.frame_kind = 2'd3; send(c, 0);
		send(make_cmd(KIND_RELEASE, 0), 0);

		// Random: mostly chains and count changes on low frames.
		for (int i = 0; i < 280; i++) begin
			gaps = (i < 80 || i > 140);
			case ($urandom_range(9))
				0, 1: build_chain(gaps, $urandom_range(8));
				2: begin
					c = make_cmd(KIND_ALLOC, 0);
					c.parent_frame = 10'($urandom_range(15));
					send(c, gaps);
				end
				3: begin
					c = make_cmd(KIND_LOOKUP, 0);
					c.owner = 6'($urandom_range(3));
					c.page_number = 20'($urandom_range(3));
					send(c, gaps);
				end
				4: send(make_cmd(KIND_FREE, $urandom_range(20)), gaps);
				5: send(make_cmd(KIND_RETAIN, $urandom_range(20)), gaps);
				6, 7: send(make_cmd(KIND_RELEASE, $urandom_range(20)), gaps);
				default: send(cmd_t'($bits(cmd_t)'({$urandom, $urandom})), gaps);
			endcase
			if (i == 180) begin
				// Hold off until the block has answered everything.
				guard = 0;
				while (pending != 0 && guard < 100000) begin
					@(posedge clk);
					guard++;
				end
			end
		end

		guard = 0;
		while ((pending != 0 || busy) && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (2100) @(posedge clk);
		$display("Sent %0d commands: directed cascades, empty-table and bad-kind cases,", sent);
		$display("and random chains, lookups, frees, retains and releases.");
		if (fail_count == 0 && pending == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end
endmodule
